/* rtl/ple_pkg.sv */
// Shared types, constants and helper functions for the Potts lattice energy unit.
package ple_pkg;

  // Lattice geometry
  localparam int MAX_SIDE = 64;
  localparam int IDX_W    = 6;
  localparam int SIDE_W   = 7;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int SPIN_W   = 8;

  // Datapath widths
  localparam int J_W      = 16;
  localparam int ENERGY_W = 30;
  localparam int CNT_W    = $clog2(2 * MAX_SIDE * MAX_SIDE) + 1;
  localparam int ACT_W    = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TOTAL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SIDE     = 1'b0;
  localparam logic CFG_COUPLING = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET     = SIDE_W'(MAX_SIDE);
  localparam logic [J_W-1:0]    COUPLING_RESET = 16'sd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_WRITE,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_SCAN,
    ST_DRAIN,
    ST_MULT,
    ST_DONE
  } ple_state_t;

  // Which sites the memory ports read this cycle
  typedef enum logic [2:0] {
    RD_NONE,
    RD_Q0,
    RD_Q1,
    RD_Q2,
    RD_SCAN
  } ple_rd_t;

  typedef struct packed {
    logic    capture;
    logic    wr_en;
    ple_rd_t rd;
    logic    mul;
    logic    load_out;
  } ple_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             scan_end;
    logic             out_free;
  } ple_status_t;

  // Periodic step down, wrapping to side-1
  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v,
                                                input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] sm1;
    sm1 = s - SIDE_W'(1);
    return (v == '0) ? sm1[IDX_W-1:0] : v - IDX_W'(1);
  endfunction

  // Periodic step up, wrapping to zero
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v,
                                                input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] vp1;
    vp1 = SIDE_W'(v) + SIDE_W'(1);
    return (vp1 >= s) ? '0 : vp1[IDX_W-1:0];
  endfunction

  // Neighbor term: +1 if it matches the old spin, -1 if it matches the new one
  function automatic logic signed [2:0] nb_term(input logic [SPIN_W-1:0] n,
                                                input logic [SPIN_W-1:0] old,
                                                input logic [SPIN_W-1:0] sp);
    logic signed [2:0] t;
    t = 3'sd0;
    if (n == old) t = t + 3'sd1;
    if (n == sp)  t = t - 3'sd1;
    return t;
  endfunction

endpackage

/* rtl/ple_ctrl.sv */
// Sequencing state machine for the Potts lattice energy unit.
module ple_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ple_pkg::ple_status_t status,
  output ple_pkg::ple_cmd_t    cmd
);

  ple_pkg::ple_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ple_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ple_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ple_pkg::ST_DISP;
      end
      ple_pkg::ST_DISP: begin
        case (status.act)
          ple_pkg::ACT_WRITE: state_nxt = ple_pkg::ST_WRITE;
          ple_pkg::ACT_QUERY: state_nxt = ple_pkg::ST_Q0;
          ple_pkg::ACT_TOTAL: state_nxt = ple_pkg::ST_SCAN;
          default:            state_nxt = ple_pkg::ST_MULT;
        endcase
      end
      ple_pkg::ST_WRITE: state_nxt = ple_pkg::ST_MULT;
      ple_pkg::ST_Q0:    state_nxt = ple_pkg::ST_Q1;
      ple_pkg::ST_Q1:    state_nxt = ple_pkg::ST_Q2;
      ple_pkg::ST_Q2:    state_nxt = ple_pkg::ST_Q3;
      ple_pkg::ST_Q3:    state_nxt = ple_pkg::ST_MULT;
      ple_pkg::ST_SCAN: begin
        if (status.scan_end) state_nxt = ple_pkg::ST_DRAIN;
      end
      ple_pkg::ST_DRAIN: state_nxt = ple_pkg::ST_MULT;
      ple_pkg::ST_MULT:  state_nxt = ple_pkg::ST_DONE;
      ple_pkg::ST_DONE: begin
        if (status.out_free) state_nxt = ple_pkg::ST_IDLE;
      end
      default: state_nxt = ple_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.wr_en    = 1'b0;
    cmd.rd       = ple_pkg::RD_NONE;
    cmd.mul      = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ple_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ple_pkg::ST_WRITE: cmd.wr_en = 1'b1;
      ple_pkg::ST_Q0:    cmd.rd = ple_pkg::RD_Q0;
      ple_pkg::ST_Q1:    cmd.rd = ple_pkg::RD_Q1;
      ple_pkg::ST_Q2:    cmd.rd = ple_pkg::RD_Q2;
      ple_pkg::ST_SCAN:  cmd.rd = ple_pkg::RD_SCAN;
      ple_pkg::ST_MULT:  cmd.mul = 1'b1;
      ple_pkg::ST_DONE:  cmd.load_out = status.out_free;
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted request always goes to dispatch next
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ple_pkg::ST_DISP))
    else $error("accepted request did not dispatch");

  // The result register is only loaded when it can take a value
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a pending result");
`endif

endmodule

/* rtl/ple_datapath.sv */
// Spin memory, site addressing, match counting, multiply and result register.
module ple_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  // request fields
  input  logic [ple_pkg::ACT_W-1:0]     in_action,
  input  logic [ple_pkg::IDX_W-1:0]     in_row,
  input  logic [ple_pkg::IDX_W-1:0]     in_column,
  input  logic [ple_pkg::SPIN_W-1:0]    in_spin,
  // configuration
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [ple_pkg::J_W-1:0]       cfg_data,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ple_pkg::ENERGY_W-1:0] out_energy,
  // control
  input  ple_pkg::ple_cmd_t             cmd,
  output ple_pkg::ple_status_t          status
);

  // Configuration registers
  logic [ple_pkg::SIDE_W-1:0]     side_r;
  logic signed [ple_pkg::J_W-1:0] coupling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r     <= ple_pkg::SIDE_RESET;
      coupling_r <= ple_pkg::COUPLING_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ple_pkg::CFG_SIDE) begin
        side_r <= cfg_data[ple_pkg::SIDE_W-1:0];
      end else begin
        coupling_r <= cfg_data;
      end
    end
  end

  // Effective side, saturated into 2..MAX_SIDE
  logic [ple_pkg::SIDE_W-1:0] side_eff;
  always_comb begin
    if (side_r < ple_pkg::SIDE_W'(2)) begin
      side_eff = ple_pkg::SIDE_W'(2);
    end else if (side_r > ple_pkg::SIDE_W'(ple_pkg::MAX_SIDE)) begin
      side_eff = ple_pkg::SIDE_W'(ple_pkg::MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
  end

  // Latched request
  logic [ple_pkg::ACT_W-1:0]  act_r;
  logic [ple_pkg::IDX_W-1:0]  row_r, col_r;
  logic [ple_pkg::SPIN_W-1:0] spin_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      row_r  <= in_row;
      col_r  <= in_column;
      spin_r <= in_spin;
    end
  end

  logic on_lattice;
  assign on_lattice = (ple_pkg::SIDE_W'(row_r) < side_eff) &&
                      (ple_pkg::SIDE_W'(col_r) < side_eff);

  // Raster scan counters
  logic [ple_pkg::IDX_W-1:0] scan_i_r, scan_i_nxt, scan_j_r, scan_j_nxt;
  logic [ple_pkg::SIDE_W-1:0] side_m1;
  logic scan_j_last;

  assign side_m1     = side_eff - ple_pkg::SIDE_W'(1);
  assign scan_j_last = (ple_pkg::SIDE_W'(scan_j_r) == side_m1);

  always_comb begin
    scan_i_nxt = scan_i_r;
    scan_j_nxt = scan_j_r;
    if (cmd.capture) begin
      scan_i_nxt = '0;
      scan_j_nxt = '0;
    end else if (cmd.rd == ple_pkg::RD_SCAN) begin
      if (scan_j_last) begin
        scan_j_nxt = '0;
        scan_i_nxt = scan_i_r + ple_pkg::IDX_W'(1);
      end else begin
        scan_j_nxt = scan_j_r + ple_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_i_r <= scan_i_nxt;
    scan_j_r <= scan_j_nxt;
  end

  // Read address selection for the two memory ports
  logic [ple_pkg::ADDR_W-1:0] addr_a, addr_b, addr_w;
  always_comb begin
    case (cmd.rd)
      ple_pkg::RD_Q0: begin
        addr_a = {row_r, col_r};
        addr_b = {ple_pkg::wrap_dec(row_r, side_eff), col_r};
      end
      ple_pkg::RD_Q1: begin
        addr_a = {ple_pkg::wrap_inc(row_r, side_eff), col_r};
        addr_b = {row_r, ple_pkg::wrap_dec(col_r, side_eff)};
      end
      ple_pkg::RD_Q2: begin
        addr_a = {row_r, ple_pkg::wrap_inc(col_r, side_eff)};
        addr_b = addr_a;
      end
      ple_pkg::RD_SCAN: begin
        addr_a = {scan_i_r, scan_j_r};
        addr_b = {ple_pkg::wrap_inc(scan_i_r, side_eff), scan_j_r};
      end
      default: begin
        addr_a = {row_r, col_r};
        addr_b = addr_a;
      end
    endcase
  end
  assign addr_w = {row_r, col_r};

  // Spin memory: one write port, two registered read ports
  logic [ple_pkg::SPIN_W-1:0] mem [ple_pkg::DEPTH];
  logic [ple_pkg::SPIN_W-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && on_lattice) begin
      mem[addr_w] <= spin_r;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // Tag and column flags travel with the read data
  ple_pkg::ple_rd_t rd_tag_r;
  logic col_first_d_r, col_last_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= ple_pkg::RD_NONE;
    end else begin
      rd_tag_r <= cmd.rd;
    end
    col_first_d_r <= (scan_j_r == '0);
    col_last_d_r  <= scan_j_last;
  end

  // Query difference and total bond count
  logic [ple_pkg::SPIN_W-1:0] old_r, prev_r, first_r;
  logic signed [3:0]          diff_r, diff_nxt;
  logic [ple_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]                 bond_inc;

  always_comb begin
    bond_inc = 2'd0;
    if (rd_a_r == rd_b_r) bond_inc = bond_inc + 2'd1;
    if (!col_first_d_r && (rd_a_r == prev_r)) bond_inc = bond_inc + 2'd1;
    if (col_last_d_r && (rd_a_r == first_r)) bond_inc = bond_inc + 2'd1;
  end

  always_comb begin
    diff_nxt  = diff_r;
    count_nxt = count_r;
    if (cmd.capture) begin
      diff_nxt  = '0;
      count_nxt = '0;
    end else begin
      case (rd_tag_r)
        ple_pkg::RD_Q0: diff_nxt = diff_r + 4'(ple_pkg::nb_term(rd_b_r, rd_a_r, spin_r));
        ple_pkg::RD_Q1: diff_nxt = diff_r + 4'(ple_pkg::nb_term(rd_a_r, old_r, spin_r))
                                          + 4'(ple_pkg::nb_term(rd_b_r, old_r, spin_r));
        ple_pkg::RD_Q2: diff_nxt = diff_r + 4'(ple_pkg::nb_term(rd_a_r, old_r, spin_r));
        ple_pkg::RD_SCAN: count_nxt = count_r + ple_pkg::CNT_W'(bond_inc);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    diff_r  <= diff_nxt;
    count_r <= count_nxt;
    if (rd_tag_r == ple_pkg::RD_Q0) old_r <= rd_a_r;
    if (rd_tag_r == ple_pkg::RD_SCAN) begin
      prev_r <= rd_a_r;
      if (col_first_d_r) first_r <= rd_a_r;
    end
  end

  // Multiply by J
  logic signed [ple_pkg::CNT_W:0]         factor;
  logic signed [ple_pkg::CNT_W+ple_pkg::J_W:0] prod;
  logic signed [ple_pkg::ENERGY_W-1:0]    energy_r;

  always_comb begin
    case (act_r)
      ple_pkg::ACT_QUERY: begin
        factor = (on_lattice && (old_r != spin_r)) ? (ple_pkg::CNT_W+1)'(diff_r) : '0;
      end
      ple_pkg::ACT_TOTAL: factor = -$signed({1'b0, count_r});
      default:            factor = '0;
    endcase
  end
  assign prod = factor * coupling_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) energy_r <= prod[ple_pkg::ENERGY_W-1:0];
  end

  // Result register
  logic out_valid_r, out_valid_nxt;
  logic signed [ple_pkg::ENERGY_W-1:0] out_energy_r;

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.load_out) out_energy_r <= energy_r;
  end

  assign out_valid  = out_valid_r;
  assign out_energy = out_energy_r;

  // Status to the controller
  assign status.act      = act_r;
  assign status.scan_end = (ple_pkg::SIDE_W'(scan_i_r) == side_m1) && scan_j_last;
  assign status.out_free = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  // Memory writes only happen for write requests
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (act_r == ple_pkg::ACT_WRITE))
    else $error("spin write outside a write request");

  // The scan never leaves the active lattice
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd == ple_pkg::RD_SCAN) |->
      ((ple_pkg::SIDE_W'(scan_i_r) < side_eff) && (ple_pkg::SIDE_W'(scan_j_r) < side_eff)))
    else $error("scan address beyond the active side");
`endif

endmodule

/* rtl/potts_lattice_energy_unit.sv */
// Top level of the Potts lattice energy unit.
//
// Holds a periodic square lattice of up to 64 x 64 eight-bit Potts spins in a
// single memory with one write port and two read ports, and answers one request
// at a time, taking the next request only after the last result is loaded. A
// spin write passes through dispatch, write, multiply and done; an energy
// change query makes three rounds of memory reads for the site and its four
// neighbors, then collects the last read; a total energy request makes a
// raster walk that reads one site and the site below it per cycle; the unused
// action goes from dispatch straight to the multiply. A result still waiting
// for out_tready holds the following request in its final state until the
// result is taken. Each request gives one result: the energy in signed Q22.8
// (zero for writes and the unused action).
// Sites must be written before they are read; the memory is not cleared after
// reset. Configuration may be written only while the unit is idle.
module potts_lattice_energy_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request: action[1:0], row[7:2], column[13:8], spin[21:14], zero fill
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // result: energy[29:0], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // configuration: index 0 side, index 1 coupling
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  ple_pkg::ple_cmd_t    cmd;
  ple_pkg::ple_status_t status;
  logic signed [ple_pkg::ENERGY_W-1:0] energy;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ple_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tdata[1:0]),
    .in_row     (in_tdata[7:2]),
    .in_column  (in_tdata[13:8]),
    .in_spin    (in_tdata[21:14]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_energy (energy),
    .cmd        (cmd),
    .status     (status)
  );

  // Pack the result
  assign out_tdata = {{(ple_pkg::OUT_W - ple_pkg::ENERGY_W){1'b0}}, energy};

endmodule
